// ===== rtl/htsp_pkg.sv =====
// Shared types, codes and tag-name lookup for the HTML tag stripper.
package htsp_pkg;

  localparam int KIND_W     = 2;
  localparam int MODE_W     = 2;
  localparam int SEL_W      = 2;
  localparam int TAG_CMP_N  = 10;
  localparam int TAG_LEN_W  = 5;

  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARA = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOC  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_TEXT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NAME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REST = 2'd2;

  localparam logic [SEL_W-1:0] SEL_SPACE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_CHAR  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_PEND  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_FINAL = 2'd3;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef logic [TAG_CMP_N-1:0][7:0] tag_name_t;

  typedef struct packed {
    logic             accept;
    logic             ld_out;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic dec_text_char;
    logic dec_pending;
    logic dec_para_end;
    logic dec_last;
    logic out_free;
    logic drain_done;
    logic last_r;
  } sts_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic name_ends(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_SLASH);
  endfunction

  // name[0] is the first character; len already excludes empty names.
  function automatic logic tag_is_block(input tag_name_t name,
                                        input logic [TAG_LEN_W-1:0] len);
    logic m_p, m_div, m_two, m_bq;
    m_p   = (len == TAG_LEN_W'(1)) && (name[0] == "p");
    m_div = (len == TAG_LEN_W'(3)) && ({name[0], name[1], name[2]} == "div");
    m_two = (len == TAG_LEN_W'(2)) &&
            (({name[0], name[1]} == "br") || ({name[0], name[1]} == "li") ||
             ((name[0] == "h") && (name[1] >= "1") && (name[1] <= "6")));
    m_bq  = (len == TAG_LEN_W'(10)) &&
            ({name[0], name[1], name[2], name[3], name[4],
              name[5], name[6], name[7], name[8], name[9]} == "blockquote");
    return m_p || m_div || m_two || m_bq;
  endfunction

endpackage

// ===== rtl/htsp_if.sv =====
// Request channel interfaces: HTML bytes in, stripped text results out.
interface htsp_in_if import htsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source(output valid, output data_byte, output is_last, input ready);
  modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

interface htsp_out_if import htsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [7:0]        text_byte;
  logic              doc_end;
  logic              run_last;
  logic              space_dropped;

  modport source(output valid, output kind, output text_byte, output doc_end,
                 output run_last, output space_dropped, input ready);
  modport sink(input valid, input kind, input text_byte, input doc_end,
               input run_last, input space_dropped, output ready);
endinterface

// ===== rtl/htsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module htsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/htsp_datapath.sv =====
// Datapath: parser state, tag name, whitespace buffer and result register.
module htsp_datapath import htsp_pkg::*; #(
  parameter int SPACE_DEPTH  = 32,
  parameter int MAX_TAG_NAME = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [7:0]        in_data_byte,
  input  logic              in_is_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [7:0]        out_text_byte,
  output logic              out_doc_end,
  output logic              out_run_last,
  output logic              out_space_dropped
);

  localparam int CNT_W  = $clog2(SPACE_DEPTH + 1);
  localparam int AW     = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(MAX_TAG_NAME + 1);
  localparam int NIDX_W = $clog2(MAX_TAG_NAME);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              first_r, first_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              long_r, long_nxt;
  logic              open_r, open_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [7:0]        chars_r [MAX_TAG_NAME];

  logic [7:0]        byte_r;
  logic              last_r;
  logic              fl_r;
  logic [CNT_W-1:0]  drain_n_r;
  logic              final_open_r;
  logic [CNT_W-1:0]  k_r;
  logic [CNT_W-1:0]  k_inc;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [7:0]        out_text_byte_r;
  logic              out_doc_end_r;
  logic              out_run_last_r;
  logic              out_space_dropped_r;

  logic [7:0]        c;
  logic [7:0]        lc;
  logic              tag_done;
  logic              text_char;
  logic              block;
  logic              ram_we;
  logic              name_we;
  logic              open_after;
  logic              para_end;
  tag_name_t         name_vec;
  logic [7:0]        ram_rd;

  always_comb begin
    for (int i = 0; i < TAG_CMP_N; i++) begin
      name_vec[i] = chars_r[i];
    end
  end

  assign c     = in_data_byte;
  assign lc    = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? c + CASE_OFS : c;
  assign block = !long_r && (len_r != '0) &&
                 tag_is_block(name_vec, TAG_LEN_W'(len_r));

  always_comb begin
    mode_nxt  = mode_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    long_nxt  = long_r;
    open_nxt  = open_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    tag_done  = 1'b0;
    text_char = 1'b0;
    ram_we    = 1'b0;
    name_we   = 1'b0;
    unique case (mode_r)
      MODE_TEXT: begin
        if (c == CH_LT) begin
          mode_nxt  = MODE_NAME;
          first_nxt = 1'b1;
          len_nxt   = '0;
          long_nxt  = 1'b0;
        end else if (is_space(c)) begin
          if (open_r) begin
            if (cnt_r < CNT_W'(SPACE_DEPTH)) begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else begin
          text_char = 1'b1;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          open_nxt  = 1'b1;
        end
      end
      MODE_NAME: begin
        if (c == CH_GT) begin
          tag_done = 1'b1;
        end else if (first_r && (c == CH_SLASH)) begin
          first_nxt = 1'b0;
        end else begin
          first_nxt = 1'b0;
          if (name_ends(c)) begin
            mode_nxt = MODE_REST;
          end else if (len_r < LEN_W'(MAX_TAG_NAME)) begin
            name_we = 1'b1;
            len_nxt = len_r + LEN_W'(1);
          end else begin
            long_nxt = 1'b1;
          end
        end
      end
      default: begin
        tag_done = (c == CH_GT);
      end
    endcase

    if (tag_done) begin
      mode_nxt  = MODE_TEXT;
      first_nxt = 1'b0;
      if (block && !in_is_last) begin
        open_nxt = 1'b0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end
    end

    open_after = open_nxt;

    if (in_is_last) begin
      mode_nxt  = MODE_TEXT;
      first_nxt = 1'b0;
      len_nxt   = '0;
      long_nxt  = 1'b0;
      open_nxt  = 1'b0;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  assign para_end = tag_done && block && !in_is_last && open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      first_r <= 1'b0;
      len_r   <= '0;
      long_r  <= 1'b0;
      open_r  <= 1'b0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.accept) begin
      mode_r  <= mode_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      long_r  <= long_nxt;
      open_r  <= open_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TAG_NAME; i++) begin
      if (cmd.accept && name_we && (len_r[NIDX_W-1:0] == NIDX_W'(i))) begin
        chars_r[i] <= lc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r       <= c;
      last_r       <= in_is_last;
      fl_r         <= ovf_r;
      drain_n_r    <= cnt_r;
      final_open_r <= open_after;
    end
  end

  assign k_inc = k_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.accept) begin
      k_r <= '0;
    end else if (cmd.ld_out && (cmd.sel == SEL_SPACE)) begin
      k_r <= k_inc;
    end
  end

  htsp_ram #(
    .WIDTH(8),
    .DEPTH(SPACE_DEPTH)
  ) u_space_ram (
    .clk    (clk),
    .wr_en  (cmd.accept && ram_we),
    .wr_addr(cnt_r[AW-1:0]),
    .wr_data(c),
    .rd_addr(k_r[AW-1:0]),
    .rd_data(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      unique case (cmd.sel)
        SEL_SPACE: begin
          out_kind_r          <= KIND_TEXT;
          out_text_byte_r     <= ram_rd;
          out_doc_end_r       <= 1'b0;
          out_run_last_r      <= 1'b0;
          out_space_dropped_r <= fl_r;
        end
        SEL_CHAR: begin
          out_kind_r          <= KIND_TEXT;
          out_text_byte_r     <= byte_r;
          out_doc_end_r       <= 1'b0;
          out_run_last_r      <= !last_r;
          out_space_dropped_r <= fl_r;
        end
        SEL_PEND: begin
          out_kind_r          <= KIND_PARA;
          out_text_byte_r     <= '0;
          out_doc_end_r       <= 1'b0;
          out_run_last_r      <= 1'b1;
          out_space_dropped_r <= 1'b0;
        end
        SEL_FINAL: begin
          out_kind_r          <= final_open_r ? KIND_PARA : KIND_DOC;
          out_text_byte_r     <= '0;
          out_doc_end_r       <= 1'b1;
          out_run_last_r      <= 1'b1;
          out_space_dropped_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_text_byte     = out_text_byte_r;
  assign out_doc_end       = out_doc_end_r;
  assign out_run_last      = out_run_last_r;
  assign out_space_dropped = out_space_dropped_r;

  assign sts.dec_text_char = text_char;
  assign sts.dec_pending   = (cnt_r != '0);
  assign sts.dec_para_end  = para_end;
  assign sts.dec_last      = in_is_last;
  assign sts.out_free      = !out_valid_r || out_ready;
  assign sts.drain_done    = (k_inc == drain_n_r);
  assign sts.last_r        = last_r;

endmodule

// ===== rtl/htsp_ctrl.sv =====
// Controller: sequences input accept, whitespace drain and result loads.
module htsp_ctrl import htsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SPACE = 3'd2;
  localparam logic [2:0] ST_CHAR  = 3'd3;
  localparam logic [2:0] ST_PEND  = 3'd4;
  localparam logic [2:0] ST_FINAL = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.ld_out = 1'b0;
    cmd.sel    = SEL_CHAR;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          priority if (sts.dec_text_char) begin
            state_nxt = sts.dec_pending ? ST_READ : ST_CHAR;
          end else if (sts.dec_para_end) begin
            state_nxt = ST_PEND;
          end else if (sts.dec_last) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SPACE;
      end
      ST_SPACE: begin
        cmd.sel = SEL_SPACE;
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = sts.drain_done ? ST_CHAR : ST_READ;
        end
      end
      ST_CHAR: begin
        cmd.sel = SEL_CHAR;
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = sts.last_r ? ST_FINAL : ST_IDLE;
        end
      end
      ST_PEND: begin
        cmd.sel = SEL_PEND;
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FINAL: begin
        cmd.sel = SEL_FINAL;
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

// ===== rtl/html_tag_strip_paragraph_split.sv =====
// Top level of the HTML tag stripper with paragraph splitting.
//
//   channel   dir  payload                                            request
//   in_chan   in   data_byte[7:0], is_last                            valid & ready
//   out_chan  out  kind[1:0], text_byte[7:0], doc_end, run_last,      valid & ready
//                  space_dropped
//
// A byte is taken in the idle state; a byte that gives a result then loads the
// output register from a load state, and no new byte is taken before that.
// A text byte after N buffered whitespace bytes first drains them (one RAM read
// and one load per buffered byte); a result that closes the document adds a load.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled output holds the controller in its load state; the input is not
// taken until every result of the previous byte sits in the output register.
module html_tag_strip_paragraph_split import htsp_pkg::*; #(
  parameter int SPACE_DEPTH  = 32,
  parameter int MAX_TAG_NAME = 10
) (
  input  logic   clk,
  input  logic   rst_n,
  htsp_in_if.sink    in_chan,
  htsp_out_if.source out_chan
);

  cmd_t cmd;
  sts_t sts;

  htsp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  htsp_datapath #(
    .SPACE_DEPTH (SPACE_DEPTH),
    .MAX_TAG_NAME(MAX_TAG_NAME)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_chan.data_byte),
    .in_is_last       (in_chan.is_last),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_kind         (out_chan.kind),
    .out_text_byte    (out_chan.text_byte),
    .out_doc_end      (out_chan.doc_end),
    .out_run_last     (out_chan.run_last),
    .out_space_dropped(out_chan.space_dropped)
  );

endmodule
